// File: hdl/fdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_pkg
// Shared constants, types and FP helper functions for the dot product block.
// ----------------------------------------------------------------------------
package fdp_pkg;

    localparam logic [31:0] C_QNAN = 32'h7FC0_0000;

    typedef struct packed {
        logic [31:0] prod;
        logic        last;
    } t_prod;

    // unpacked operand: special flags, sign, biased exponent, significand
    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        zero;
        logic        sgn;
        logic [9:0]  exp;   // unsigned, value of biased exponent (subnormal -> 1)
        logic [23:0] man;   // with hidden bit
    } t_unp;

    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        zero;
        logic        sgn;
        logic signed [10:0] exp;
        logic [47:0] man;
    } t_mulst;

    function automatic t_unp f_unpack(input logic [31:0] x);
        t_unp u;
        u.sgn  = x[31];
        u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        u.zero = (x[30:0] == 31'd0);
        u.exp  = (x[30:23] == 8'd0) ? 10'd1 : {2'b00, x[30:23]};
        u.man  = {(x[30:23] != 8'd0), x[22:0]};
        return u;
    endfunction

    // count leading zeros of a 50 bit word
    function automatic logic [5:0] f_clz50(input logic [49:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd50;
        found = 1'b0;
        for (int i = 49; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 6'(49 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Round and pack: value = m * 2^(e - 49 - 127 + ...) where m[49] is the
    // weight of 2^(e-127) for a biased exponent e; sticky carries lower bits.
    function automatic logic [31:0] f_round(input logic sgn, input logic signed [11:0] e,
                                            input logic [49:0] m, input logic sticky);
        logic [5:0]          lz;
        logic [49:0]         mn;
        logic signed [11:0]  en;
        logic [11:0]         sh;
        logic [49:0]         ms;
        logic                st;
        logic [24:0]         rm;
        logic                g, s;
        logic [31:0]         res;
        lz = f_clz50(m);
        mn = m << lz;
        en = e - 12'(lz);
        st = sticky;
        ms = mn;
        if (en < 12'sd1) begin
            sh = 12'(12'sd1 - en);
            if (sh > 12'd50) begin
                st = st | (mn != 50'd0);
                ms = 50'd0;
            end else begin
                st = st | ((mn & ~({50{1'b1}} << sh)) != 50'd0);
                ms = mn >> sh;
            end
            en = 12'sd0;
        end
        g  = ms[25];
        s  = st | (ms[24:0] != 25'd0);
        rm = {1'b0, ms[49:26]};
        if (g && (s || rm[0])) rm = rm + 25'd1;
        if (en == 12'sd0) begin
            // subnormal; rounding may carry into normal range
            res = {sgn, 8'(rm[23]), rm[22:0]};
        end else begin
            if (rm[24]) begin
                rm = rm >> 1;
                en = en + 12'sd1;
            end
            if (en >= 12'sd255) res = {sgn, 8'hFF, 23'd0};
            else                res = {sgn, en[7:0], rm[22:0]};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: hdl/float_dot_product.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// float_dot_product
// Single-precision dot product: rounded multiply, then rounded accumulate.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive i_a_element, i_b_element, i_last_pair with i_push;
//   a beat is taken when i_push is high and o_full is low.
//   Result queue: while o_empty is low, o_dot_sum holds the finished sum of
//   a vector; i_pop takes it.
//   Path of the last beat to o_empty falling, with the adder idle: two
//   multiply stages, queue write, adder take; then the add result is
//   registered into o_dot_sum.
//   The accumulator's align/normalise loop must finish before the next
//   add, so the adder takes a new pair only after the previous add ends.
//   The products queue (4 deep) lets the multiplier run on while the adder
//   waits. A stalled result blocks only the next vector's last beat.
//   Reset (synchronous, low) empties all queues and sets the sum to +0.0.
// ----------------------------------------------------------------------------
module float_dot_product #(
    parameter int QDEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [31:0] i_a_element,
    input  wire logic [31:0] i_b_element,
    input  wire logic        i_last_pair,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [31:0]      o_dot_sum
);
    import fdp_pkg::*;

    t_prod w_mp, w_qp;
    logic  w_mv, w_mr, w_qv, w_qr;

    fdp_mul u_mul (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_a_element, .i_b_element,
        .i_last_pair, .o_valid(w_mv), .i_ready(w_mr), .o_prod(w_mp)
    );

    fdp_fifo #(.DEPTH(QDEPTH)) u_q (
        .i_clk, .i_rst_n, .i_valid(w_mv), .o_ready(w_mr), .i_data(w_mp),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qp)
    );

    fdp_acc u_acc (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_data(w_qp),
        .o_empty, .i_pop, .o_dot_sum
    );

endmodule
`default_nettype wire

// File: hdl/fdp_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_mul
// Front end: accepts pairs, classifies operands, multiplies and rounds.
// ----------------------------------------------------------------------------
module fdp_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic [31:0]        i_a_element,
    input  wire logic [31:0]        i_b_element,
    input  wire logic               i_last_pair,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output fdp_pkg::t_prod          o_prod
);
    import fdp_pkg::*;

    logic   r_v1, r_v2;
    t_mulst r_m1;
    logic   r_l1;
    t_prod  r_p2;
    t_unp   w_a, w_b;
    logic   w_adv2, w_adv1;
    logic signed [11:0] w_e;

    assign w_a    = f_unpack(i_a_element);
    assign w_b    = f_unpack(i_b_element);
    assign w_adv2 = !r_v2 || i_ready;
    assign w_adv1 = !r_v1 || w_adv2;
    assign o_full = !w_adv1;
    assign o_valid = r_v2;
    assign o_prod  = r_p2;
    // product of two 1.23 mants is 2.46; place bit 47 at m[49] weight 2^(e+1)
    assign w_e = 12'(r_m1.exp) + 12'sd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_push;
            if (w_adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_push) begin
            r_m1.nan  <= w_a.nan || w_b.nan || (w_a.inf && w_b.zero) || (w_b.inf && w_a.zero);
            r_m1.inf  <= w_a.inf || w_b.inf;
            r_m1.zero <= w_a.zero || w_b.zero;
            r_m1.sgn  <= w_a.sgn ^ w_b.sgn;
            r_m1.exp  <= 11'($signed({1'b0, w_a.exp}) + $signed({1'b0, w_b.exp}) - 11'sd127);
            r_m1.man  <= w_a.man * w_b.man;
            r_l1      <= i_last_pair;
        end
        if (w_adv2 && r_v1) begin
            r_p2.last <= r_l1;
            if (r_m1.nan)       r_p2.prod <= C_QNAN;
            else if (r_m1.inf)  r_p2.prod <= {r_m1.sgn, 8'hFF, 23'd0};
            else if (r_m1.zero) r_p2.prod <= {r_m1.sgn, 31'd0};
            else r_p2.prod <= f_round(r_m1.sgn, w_e, {r_m1.man, 2'b00}, 1'b0);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("product lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_prod)) else $error("product changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> (r_v1 && r_v2)) else $error("full without backlog");

endmodule
`default_nettype wire

// File: hdl/fdp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_fifo
// Short queue of rounded products between front and back.
// ----------------------------------------------------------------------------
module fdp_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  fdp_pkg::t_prod   i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output fdp_pkg::t_prod   o_data
);
    import fdp_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_prod r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic w_wr, w_rd;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_wr = i_valid && o_ready;
    assign w_rd = o_valid && i_ready;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("count overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_cnt == $past(r_cnt) + 1'b1)) else $error("count slip");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp)) else $error("pointer mismatch");

endmodule
`default_nettype wire

// File: hdl/fdp_acc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_acc
// Back end: adds each product into the running sum, emits on last beat.
// Two-stage add (align, then normalise/round); a new product is taken only after the previous add finishes.
// ----------------------------------------------------------------------------
module fdp_acc (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  fdp_pkg::t_prod   i_data,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [31:0]      o_dot_sum
);
    import fdp_pkg::*;

    logic [31:0] r_sum, r_out;
    logic        r_busy, r_ov;
    logic        r_last, r_spec;
    logic [31:0] r_spec_val;
    logic        r_sgn, r_eff_sub;
    logic [11:0] r_e;
    logic [49:0] r_big, r_sml;
    logic        r_st;
    t_unp  w_x, w_y, w_l, w_s;
    logic  w_take, w_swap;
    logic [9:0]  w_d;
    logic [49:0] w_sm, w_mask;
    logic [49:0] w_m;
    logic [31:0] w_res;

    assign o_empty = !r_ov;
    assign o_dot_sum = r_out;
    // block new product while adding, and a last product while a result waits
    assign o_ready = !r_busy && !(r_ov && i_data.last);
    assign w_take  = i_valid && o_ready;

    assign w_x = f_unpack(r_sum);
    assign w_y = f_unpack(i_data.prod);
    assign w_swap = {w_y.exp, w_y.man} > {w_x.exp, w_x.man};
    assign w_l = w_swap ? w_y : w_x;
    assign w_s = w_swap ? w_x : w_y;
    assign w_d = w_l.exp - w_s.exp;
    assign w_sm = {1'b0, w_s.man, 25'd0};
    assign w_mask = (w_d > 10'd49) ? {50{1'b1}} : ~({50{1'b1}} << w_d);

    assign w_m = r_eff_sub ? (r_big - r_sml) : (r_big + r_sml - 50'(r_st && 1'b0));
    always_comb begin
        if (r_spec)
            w_res = r_spec_val;
        else if (r_eff_sub && w_m == 50'd0 && !r_st)
            w_res = 32'd0;
        else if (r_eff_sub && r_st)
            // true difference is slightly less: borrow one ulp at the lsb
            w_res = f_round(r_sgn, 12'($signed(r_e)), w_m - 50'd1, 1'b1);
        else
            w_res = f_round(r_sgn, 12'($signed(r_e)), w_m, r_st);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_sum  <= 32'd0;
        end else begin
            if (r_ov && i_pop) r_ov <= 1'b0;
            if (w_take) r_busy <= 1'b1;
            if (r_busy) begin
                r_busy <= 1'b0;
                r_sum  <= r_last ? 32'd0 : w_res;
                if (r_last) begin
                    r_ov  <= 1'b1;
                    r_out <= w_res;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_last    <= i_data.last;
            r_sgn     <= w_l.sgn;
            r_eff_sub <= w_x.sgn ^ w_y.sgn;
            r_e       <= {2'b00, w_l.exp} + 12'd1;
            r_big     <= {1'b0, w_l.man, 25'd0};
            r_sml     <= (w_d > 10'd49) ? 50'd0 : (w_sm >> w_d);
            r_st      <= (w_sm & w_mask) != 50'd0;
            if (w_x.nan || w_y.nan || (w_x.inf && w_y.inf && (w_x.sgn != w_y.sgn))) begin
                r_spec     <= 1'b1;
                r_spec_val <= C_QNAN;
            end else if (w_x.inf) begin
                r_spec     <= 1'b1;
                r_spec_val <= r_sum;
            end else if (w_y.inf) begin
                r_spec     <= 1'b1;
                r_spec_val <= i_data.prod;
            end else if (w_x.zero && w_y.zero) begin
                r_spec     <= 1'b1;
                r_spec_val <= {w_x.sgn & w_y.sgn, 31'd0};
            end else begin
                r_spec     <= 1'b0;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy) else $error("adder stuck");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_last) |=> (r_ov && r_sum == 32'd0)) else $error("sum not cleared");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_pop) |=> $stable(r_out)) else $error("result changed");

endmodule
`default_nettype wire

// File: tb/float_dot_product_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_dot_product_test
// Drives vectors of single-precision pairs into the dot product block and
// checks every emitted sum against a bit-exact software multiply-accumulate
// with round to nearest even, subnormals kept and NaNs made canonical.
// ----------------------------------------------------------------------------
module float_dot_product_test;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic        last;
    } t_pair;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic [31:0] i_a_element = '0;
    logic [31:0] i_b_element = '0;
    logic        i_last_pair = 1'b0;
    logic        i_pop = 1'b0;
    wire         o_full;
    wire         o_empty;
    wire  [31:0] o_dot_sum;

    t_pair       pending_pairs[$];
    logic [31:0] expected_sums[$];
    logic [31:0] acc_sum = '0;
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;

    float_dot_product uut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // IEEE pieces: exact integer maths, rounding done once per operation
    function automatic logic [31:0] fp_pack(input logic sgn, input logic [319:0] mag,
                                            input int lsb);
        // value = mag * 2^lsb; return rounded binary32
        int           msb;
        int           e;
        int           shift;
        logic [319:0] q;
        logic [319:0] rem;
        logic [319:0] half;
        if (mag == 0) return {sgn, 31'd0};
        msb = 319;
        while (!mag[msb]) msb--;
        e = msb + lsb;
        if (e < -126) e = -126;
        shift = (e - 23) - lsb;
        if (shift > 0) begin
            if (shift > 319) begin
                q = 0;
                rem = mag;
                half = 0;
                half[319] = 1'b1;
                if (shift == 320) q = (rem > half) ? 1 : 0;
            end else begin
                q = mag >> shift;
                rem = mag & ((320'd1 << shift) - 1);
                half = 320'd1 << (shift - 1);
                if (rem > half || (rem == half && q[0])) q = q + 1;
            end
        end else begin
            q = mag << (-shift);
        end
        if (q[24]) begin
            q = q >> 1;
            e++;
        end
        if (e > 127) return {sgn, 8'hFF, 23'd0};
        if (!q[23]) return {sgn, 8'd0, q[22:0]};
        return {sgn, 8'(e + 127), q[22:0]};
    endfunction

    function automatic void fp_split(input logic [31:0] x, output logic [23:0] m,
                                     output int ex);
        m  = {x[30:23] != 0, x[22:0]};
        ex = ((x[30:23] == 0) ? 1 : int'(x[30:23])) - 127 - 23;
    endfunction

    function automatic bit fp_nan(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function automatic bit fp_inf(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] == 0;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] x, input logic [31:0] y);
        logic        s;
        logic [23:0] mx;
        logic [23:0] my;
        int          ex;
        int          ey;
        s = x[31] ^ y[31];
        if (fp_nan(x) || fp_nan(y)) return QNAN;
        if (fp_inf(x) || fp_inf(y)) begin
            if (x[30:0] == 0 || y[30:0] == 0) return QNAN;
            return {s, 8'hFF, 23'd0};
        end
        fp_split(x, mx, ex);
        fp_split(y, my, ey);
        return fp_pack(s, 320'(mx) * 320'(my), ex + ey);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
        logic [23:0]  mx;
        logic [23:0]  my;
        int           ex;
        int           ey;
        logic [319:0] ax;
        logic [319:0] ay;
        if (fp_nan(x) || fp_nan(y)) return QNAN;
        if (fp_inf(x) && fp_inf(y)) return (x[31] == y[31]) ? x : QNAN;
        if (fp_inf(x)) return x;
        if (fp_inf(y)) return y;
        if (x[30:0] == 0 && y[30:0] == 0) return {x[31] & y[31], 31'd0};
        fp_split(x, mx, ex);
        fp_split(y, my, ey);
        // both exponents at least -149, so align to -149 (fits 320 bits)
        ax = 320'(mx) << (ex + 149);
        ay = 320'(my) << (ey + 149);
        if (x[31] == y[31]) return fp_pack(x[31], ax + ay, -149);
        if (ax == ay) return 32'd0;
        if (ax > ay) return fp_pack(x[31], ax - ay, -149);
        return fp_pack(y[31], ay - ax, -149);
    endfunction

    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'hFF;
            1: v[30:23] = 8'h00;
            2: v[30:0] = 0;
            3, 4, 5, 6: v[30:23] = 8'($urandom_range(110, 144));
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sum_after(input t_pair p);
        return fp_add(acc_sum, fp_mul(p.a, p.b));
    endfunction

    task automatic queue_pair(input logic [31:0] a, input logic [31:0] b,
                              input logic last);
        t_pair p;
        p.a = a;
        p.b = b;
        p.last = last;
        pending_pairs.push_back(p);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_push && !o_full) begin
                acc_sum = sum_after('{i_a_element, i_b_element, i_last_pair});
                if (i_last_pair) begin
                    expected_sums.push_back(acc_sum);
                    acc_sum = '0;
                end
                void'(pending_pairs.pop_front());
            end
            if (pending_pairs.size() != 0 && (!(i_push && !o_full) || pending_pairs.size() > 0)
                && $urandom_range(0, 99) >= send_idle_pct) begin
                i_push      <= 1'b1;
                i_a_element <= pending_pairs[0].a;
                i_b_element <= pending_pairs[0].b;
                i_last_pair <= pending_pairs[0].last;
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                if (expected_sums.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected sum %h", o_dot_sum);
                end else begin
                    if (o_dot_sum !== expected_sums[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("dot_sum expected %h actual %h",
                                     expected_sums[0], o_dot_sum);
                    end
                    void'(expected_sums.pop_front());
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic random_vectors(input int pairs);
        int len;
        while (pairs > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
            for (int k = 0; k < len; k++) begin
                queue_pair(rand_float(), rand_float(), k == len - 1);
                pairs--;
            end
        end
    endtask

    task automatic drain();
        while (pending_pairs.size() != 0 || i_push || expected_sums.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_pair(32'h3F80_0000, 32'h4000_0000, 1'b1);
        queue_pair(32'h7F80_0000, 32'h0000_0000, 1'b1);
        queue_pair(32'h7FFF_FFFF, 32'h3F80_0000, 1'b1);
        queue_pair(32'h7F80_0000, 32'h3F80_0000, 1'b0);
        queue_pair(32'hFF80_0000, 32'h3F80_0000, 1'b1);
        queue_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1);
        queue_pair(32'h0000_0001, 32'h3F00_0000, 1'b1);
        queue_pair(32'h0080_0000, 32'h3F00_0000, 1'b1);
        queue_pair(32'h8000_0000, 32'h3F80_0000, 1'b1);
        queue_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
        queue_pair(32'h3F80_0000, 32'hBF80_0000, 1'b1);
        queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_pair(32'h4B80_0000, 32'h3F80_0000, 1'b0);
        queue_pair(32'h3F80_0001, 32'h3F80_0000, 1'b1);
        queue_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
        drain();

        random_vectors(180);
        drain();
        send_idle_pct = 87;
        random_vectors(120);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 87;
        random_vectors(120);
        drain();
        send_idle_pct = 35;
        recv_stall_pct = 35;
        random_vectors(120);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
        for (int k = 0; k < 40; k++) queue_pair(rand_float(), rand_float(), 1'b1);
        random_vectors(60);
        drain();

        if (mismatches == 0) $display("float_dot_product_test OK");
        else $display("float_dot_product_test NOT OK");
        $finish;
    end

    initial begin
        #2000000;
        $display("float_dot_product_test NOT OK");
        $finish;
    end

endmodule
